### rtl/kps_pkg.sv
// Shared constants and types for the key and payload sorter.
`default_nettype none

package kps_pkg;

  // Default configuration
  localparam int DEF_MAX_ITEMS     = 64;
  localparam int DEF_KEY_WIDTH     = 32;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the incoming pair into the chain
    logic shift;   // move every entry one cell towards the head
  } kps_ctrl_t;

endpackage : kps_pkg

`default_nettype wire

### rtl/kps_in_if.sv
// Input channel carrying one key and payload request per handshake.
`default_nettype none

interface kps_in_if #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] sort_key;
  logic [PAYLOAD_WIDTH-1:0]    payload;
  logic                        last_of_set;

  modport source (output valid, output sort_key, output payload, output last_of_set,
                  input ready);
  modport sink   (input valid, input sort_key, input payload, input last_of_set,
                  output ready);
endinterface : kps_in_if

`default_nettype wire

### rtl/kps_out_if.sv
// Output channel carrying one sorted result request per handshake.
`default_nettype none

interface kps_out_if #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] sorted_key;
  logic [PAYLOAD_WIDTH-1:0]    sorted_payload;
  logic                        final_result;
  logic                        overflowed;

  modport source (output valid, output sorted_key, output sorted_payload,
                  output final_result, output overflowed, input ready);
  modport sink   (input valid, input sorted_key, input sorted_payload,
                  input final_result, input overflowed, output ready);
endinterface : kps_out_if

`default_nettype wire

### rtl/kps_cell.sv
// One cell of the insertion chain: holds a single key and payload entry.
`default_nettype none

module kps_cell #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire kps_pkg::kps_ctrl_t      ctrl,
  input  wire signed [KEY_WIDTH-1:0]   new_key,
  input  wire [PAYLOAD_WIDTH-1:0]      new_payload,
  input  wire signed [KEY_WIDTH-1:0]   left_key,
  input  wire [PAYLOAD_WIDTH-1:0]      left_payload,
  input  wire                          left_valid,
  input  wire                          left_gt,
  input  wire signed [KEY_WIDTH-1:0]   right_key,
  input  wire [PAYLOAD_WIDTH-1:0]      right_payload,
  input  wire                          right_valid,
  output logic signed [KEY_WIDTH-1:0]  key,
  output logic [PAYLOAD_WIDTH-1:0]     payload,
  output logic                         valid,
  output logic                         gt
);
  import kps_pkg::*;

  // An empty cell counts as holding a key above everything
  assign gt = !valid || (key > new_key);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && gt) begin
      valid <= left_gt ? left_valid : 1'b1;
    end
  end

  // Entry data: shift towards the head, or make room and take the new pair
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key     <= right_key;
      payload <= right_payload;
    end else if (ctrl.insert && gt) begin
      if (left_gt) begin
        key     <= left_key;
        payload <= left_payload;
      end else begin
        key     <= new_key;
        payload <= new_payload;
      end
    end
  end

endmodule : kps_cell

`default_nettype wire

### rtl/key_payload_sorter.sv
// Top level: collects a set of key and payload pairs and emits it in key order.
//
//  channel  dir  port     fields
//  -------  ---  -------  ---------------------------------------------------
//  pairs    in   pairs    sort_key, payload, last_of_set
//  results  out  results  sorted_key, sorted_payload, final_result, overflowed
//
// Loading accepts one pair per cycle: every cell compares with the broadcast key
// and the chain opens a gap in a single step. After the pair marked last, the n
// stored pairs leave from the head cell at one per cycle and the input is held
// off until the final result is taken. Synchronous reset empties the chain at
// once. A stall on the results side simply holds the head cell and the counter.
`default_nettype none

module key_payload_sorter #(
  parameter int MAX_ITEMS     = kps_pkg::DEF_MAX_ITEMS,
  parameter int KEY_WIDTH     = kps_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = kps_pkg::DEF_PAYLOAD_WIDTH
) (
  input wire       clk,
  input wire       rst,
  kps_in_if.sink   pairs,
  kps_out_if.source results
);
  import kps_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]  count;
  logic           draining;
  logic           oflow;
  logic           in_acc;
  logic           out_acc;
  logic           full;
  kps_ctrl_t      ctrl;

  logic signed [KEY_WIDTH-1:0] cell_key     [MAX_ITEMS];
  logic [PAYLOAD_WIDTH-1:0]    cell_payload [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]        cell_valid;
  logic [MAX_ITEMS-1:0]        cell_gt;

  // Handshakes
  assign pairs.ready = !draining;
  assign in_acc      = pairs.valid && pairs.ready;
  assign out_acc     = results.valid && results.ready;
  assign full        = (count == CW'(MAX_ITEMS));

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
      oflow    <= 1'b0;
    end else if (in_acc) begin
      if (full) begin
        oflow <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
      if (pairs.last_of_set) begin
        draining <= 1'b1;
      end
    end else if (out_acc) begin
      count <= count - CW'(1);
      if (results.final_result) begin
        draining <= 1'b0;
        oflow    <= 1'b0;
      end
    end
  end

  // Insertion chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] l_key;
    logic [PAYLOAD_WIDTH-1:0]    l_payload;
    logic                        l_valid;
    logic                        l_gt;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [PAYLOAD_WIDTH-1:0]    r_payload;
    logic                        r_valid;

    if (i == 0) begin : g_head
      assign l_key     = '0;
      assign l_payload = '0;
      assign l_valid   = 1'b0;
      assign l_gt      = 1'b0;
    end else begin : g_body
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
      assign l_valid   = cell_valid[i-1];
      assign l_gt      = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_key     = '0;
      assign r_payload = '0;
      assign r_valid   = 1'b0;
    end else begin : g_inner
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
      assign r_valid   = cell_valid[i+1];
    end

    kps_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .new_key       (pairs.sort_key),
      .new_payload   (pairs.payload),
      .left_key      (l_key),
      .left_payload  (l_payload),
      .left_valid    (l_valid),
      .left_gt       (l_gt),
      .right_key     (r_key),
      .right_payload (r_payload),
      .right_valid   (r_valid),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .valid         (cell_valid[i]),
      .gt            (cell_gt[i])
    );
  end

  // Results come from the head cell
  assign results.valid          = draining;
  assign results.sorted_key     = cell_key[0];
  assign results.sorted_payload = cell_payload[0];
  assign results.final_result   = (count == CW'(1));
  assign results.overflowed     = oflow;

  // Checks
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("chain occupancy differs from item count");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> cell_valid[0])
    else $error("result offered from an empty head cell");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count above capacity");

  a_set_end: assert property (@(posedge clk) disable iff (rst)
    (out_acc && results.final_result) |=> (count == '0) && !draining && !oflow)
    else $error("set state not cleared after final result");

endmodule : key_payload_sorter

`default_nettype wire

### tb/key_payload_sorter_test.sv
// Self-checking testbench for the key and payload sorter: sets in, sorted results out.
`default_nettype none

module key_payload_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = kps_pkg::DEF_MAX_ITEMS;
  localparam int KW          = kps_pkg::DEF_KEY_WIDTH;
  localparam int PW          = kps_pkg::DEF_PAYLOAD_WIDTH;
  localparam int PAIR_BUDGET = 370;
  localparam int CYCLE_LIMIT = 200000;

  // One sorted result as it leaves the block
  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [PW-1:0]        payload;
    logic                 last_res;
    logic                 ovf;
  } sorted_res_t;

  // One row of the directed stimulus; want is only used when typed is set
  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [PW-1:0]        payload;
    logic                 last;
    logic                 typed;
    sorted_res_t          want;
  } dir_row_t;

  // How keys of a random set are drawn
  typedef enum int {MIX_ANY, MIX_CLUSTER, MIX_EDGES} key_mix_t;

  localparam sorted_res_t NO_RES = '0;

  // Directed part: single-pair sets at the key extremes (typed), then mixed
  // signs with ties, all-equal keys, descending and ascending sets
  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, '{32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0}},
    '{32'h80000000, 32'h00000000, 1'b1, 1'b1, '{32'h80000000, 32'h00000000, 1'b1, 1'b0}},
    '{32'h00000000, 32'hA5A5A5A5, 1'b1, 1'b1, '{32'h00000000, 32'hA5A5A5A5, 1'b1, 1'b0}},
    '{32'hFFFFFFFF, 32'h5A5A5A5A, 1'b1, 1'b1, '{32'hFFFFFFFF, 32'h5A5A5A5A, 1'b1, 1'b0}},
    '{32'h00010000, 32'h00000011, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF0000, 32'h00000012, 1'b0, 1'b0, NO_RES},
    '{32'h7FFFFFFF, 32'h00000013, 1'b0, 1'b0, NO_RES},
    '{32'h80000000, 32'h00000014, 1'b0, 1'b0, NO_RES},
    '{32'h00010000, 32'h00000015, 1'b0, 1'b0, NO_RES},
    '{32'h00000000, 32'h00000016, 1'b0, 1'b0, NO_RES},
    '{32'h80000000, 32'h00000017, 1'b1, 1'b0, NO_RES},
    '{32'h00000005, 32'h00000021, 1'b0, 1'b0, NO_RES},
    '{32'h00000005, 32'h00000022, 1'b0, 1'b0, NO_RES},
    '{32'h00000005, 32'h00000023, 1'b1, 1'b0, NO_RES},
    '{32'h00000040, 32'h00000031, 1'b0, 1'b0, NO_RES},
    '{32'h00000030, 32'h00000032, 1'b0, 1'b0, NO_RES},
    '{32'h00000020, 32'h00000033, 1'b0, 1'b0, NO_RES},
    '{32'h00000010, 32'h00000034, 1'b1, 1'b0, NO_RES},
    '{32'hFFFFFFFE, 32'h00000041, 1'b0, 1'b0, NO_RES},
    '{32'hFFFFFFFF, 32'h00000042, 1'b1, 1'b0, NO_RES},
    '{32'h7FFFFFFF, 32'h00000051, 1'b0, 1'b0, NO_RES},
    '{32'h80000001, 32'h00000052, 1'b1, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  kps_in_if  #(.KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)) pairs_if ();
  kps_out_if #(.KEY_WIDTH(KW), .PAYLOAD_WIDTH(PW)) results_if ();

  key_payload_sorter #(
    .MAX_ITEMS    (CAPACITY),
    .KEY_WIDTH    (KW),
    .PAYLOAD_WIDTH(PW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pairs  (pairs_if),
    .results(results_if)
  );

  // Predictor state: the sorted chain of the set being collected
  logic signed [KW-1:0] chain_key [CAPACITY];
  logic [PW-1:0]        chain_pay [CAPACITY];
  int                   chain_count;
  bit                   chain_dropped;
  sorted_res_t          sorted_due [$];

  // Side information travelling with the request on the pairs channel
  bit          cur_typed;
  sorted_res_t cur_want;

  int cycle_count;
  int mismatches;
  int sets_done;
  int pairs_done;
  int results_done;
  int dropped_sets;
  int pairs_sent;
  bit ready_steady;
  int stall_left;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Insert a pair after all stored keys <= its own; on the last pair
  // release the whole set in order, flagged if anything was dropped
  function automatic void absorb_pair(logic signed [KW-1:0] key, logic [PW-1:0] pay,
                                      logic last, bit keep_results);
    int pos;
    sorted_res_t r;
    if (chain_count < CAPACITY) begin
      pos = chain_count;
      while (pos > 0 && chain_key[pos-1] > key) begin
        chain_key[pos] = chain_key[pos-1];
        chain_pay[pos] = chain_pay[pos-1];
        pos--;
      end
      chain_key[pos] = key;
      chain_pay[pos] = pay;
      chain_count++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < chain_count; k++) begin
        r.key      = chain_key[k];
        r.payload  = chain_pay[k];
        r.last_res = (k == chain_count - 1);
        r.ovf      = chain_dropped;
        if (keep_results) sorted_due.push_back(r);
      end
      if (chain_dropped) dropped_sets++;
      sets_done++;
      chain_count   = 0;
      chain_dropped = 1'b0;
    end
  endfunction

  // Compare one result against the oldest one due
  task automatic check_result();
    sorted_res_t want;
    results_done++;
    if (sorted_due.size() == 0) begin
      $error("unexpected result: sorted_key %0d sorted_payload %0h",
             results_if.sorted_key, results_if.sorted_payload);
      mismatches++;
    end else begin
      want = sorted_due.pop_front();
      if (results_if.sorted_key !== want.key) begin
        $error("sorted_key: expected %0d, got %0d", want.key, results_if.sorted_key);
        mismatches++;
      end
      if (results_if.sorted_payload !== want.payload) begin
        $error("sorted_payload: expected %0h, got %0h", want.payload,
               results_if.sorted_payload);
        mismatches++;
      end
      if (results_if.final_result !== want.last_res) begin
        $error("final_result: expected %0b, got %0b", want.last_res,
               results_if.final_result);
        mismatches++;
      end
      if (results_if.overflowed !== want.ovf) begin
        $error("overflowed: expected %0b, got %0b", want.ovf, results_if.overflowed);
        mismatches++;
      end
    end
  endtask

  // Monitor: results first, then the accepted pair feeds the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) check_result();
      if (pairs_if.valid && pairs_if.ready) begin
        pairs_done++;
        absorb_pair(pairs_if.sort_key, pairs_if.payload, pairs_if.last_of_set, !cur_typed);
        if (cur_typed) sorted_due.push_back(cur_want);
      end
    end
  end

  // Results side back-pressure, with stretches of no stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) ready_steady = !ready_steady;
    if (stall_left > 0) begin
      results_if.ready <= 1'b0;
      stall_left--;
    end else begin
      results_if.ready <= 1'b1;
      if (!ready_steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one request and wait for it to be taken
  task automatic send_pair(logic signed [KW-1:0] key, logic [PW-1:0] pay, logic last,
                           bit typed, sorted_res_t want, int gap);
    if (gap > 0) begin
      pairs_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pairs_if.valid       <= 1'b1;
    pairs_if.sort_key    <= key;
    pairs_if.payload     <= pay;
    pairs_if.last_of_set <= last;
    cur_typed            <= typed;
    cur_want             <= want;
    pairs_sent++;
    @(posedge clk);
    while (!pairs_if.ready) @(posedge clk);
  endtask

  function automatic logic signed [KW-1:0] draw_key(key_mix_t mix);
    case (mix)
      MIX_CLUSTER: return $signed($urandom_range(0, 8)) - 4;
      MIX_EDGES: begin
        case ($urandom_range(0, 5))
          0: return 32'h80000000;
          1: return 32'h80000001;
          2: return 32'h7FFFFFFF;
          3: return 32'h7FFFFFFE;
          4: return 32'hFFFFFFFF;
          default: return 32'h00000000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Send one whole set of random pairs
  task automatic send_set(int size);
    key_mix_t mix;
    bit steady;
    mix    = key_mix_t'($urandom_range(0, 2));
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < size; i++) begin
      send_pair(draw_key(mix), $urandom, (i == size - 1), 1'b0, NO_RES,
                steady ? 0 : pick_gap());
    end
  endtask

  initial begin
    rst                  = 1'b1;
    pairs_if.valid       = 1'b0;
    pairs_if.sort_key    = '0;
    pairs_if.payload     = '0;
    pairs_if.last_of_set = 1'b0;
    results_if.ready     = 1'b0;
    cur_typed            = 1'b0;
    cur_want             = NO_RES;
    chain_count          = 0;
    chain_dropped        = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_pair(DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].payload, DIRECTED_ROWS[i].last,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want, pick_gap());
    end

    // A set exactly at capacity, then one three pairs over it so the marked pair is dropped
    send_set(CAPACITY);
    send_set(CAPACITY + 3);

    // Random sets, mostly small, now and then around capacity
    while (pairs_sent < PAIR_BUDGET) begin
      if ($urandom_range(0, 99) < 3) send_set($urandom_range(CAPACITY - 4, CAPACITY + 4));
      else send_set($urandom_range(1, 12));
    end
    pairs_if.valid <= 1'b0;

    // Drain, then allow for a late stray result
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);

    $display("covered %0d sets from %0d pairs, %0d sorted results checked",
             sets_done, pairs_done, results_done);
    $display("%0d sets exceeded capacity and were flagged", dropped_sets);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : key_payload_sorter_test

`default_nettype wire

### files.f
rtl/kps_pkg.sv
rtl/kps_in_if.sv
rtl/kps_out_if.sv
rtl/kps_cell.sv
rtl/key_payload_sorter.sv
tb/key_payload_sorter_test.sv
